>>> hw/rtl/slbp_pkg.sv
package slbp_pkg;

    localparam int STATUS_W = 3;
    localparam int TIME_W   = 32;
    localparam int IVL_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [TIME_W-1:0]   t_time;
    typedef logic [IVL_W-1:0]    t_ivl;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Link status codes.
    localparam t_status ST_STARTED    = 3'd0;
    localparam t_status ST_CONNECTING = 3'd1;
    localparam t_status ST_AP         = 3'd2;
    localparam t_status ST_STATION    = 3'd3;
    localparam t_status ST_STA_CLIENT = 3'd4;
    localparam t_status ST_AP_CLIENT  = 3'd5;
    localparam t_status ST_UNKNOWN_LO = 3'd6;
    localparam t_status ST_UNKNOWN_HI = 3'd7;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_STARTED_BLINK    = 3'd0;
    localparam t_cfg_idx CFG_CONNECTING_BLINK = 3'd1;
    localparam t_cfg_idx CFG_AP_BLINK         = 3'd2;
    localparam t_cfg_idx CFG_STATION_CYCLE    = 3'd3;
    localparam t_cfg_idx CFG_CLIENTS_CYCLE    = 3'd4;
    localparam t_cfg_idx CFG_SHORT_OFF        = 3'd5;
    localparam t_cfg_idx CFG_ACTIVE_LOW       = 3'd6;

    // Reset values of the configuration registers.
    localparam t_ivl RST_STARTED_BLINK    = 16'd1000;
    localparam t_ivl RST_CONNECTING_BLINK = 16'd200;
    localparam t_ivl RST_AP_BLINK         = 16'd500;
    localparam t_ivl RST_STATION_CYCLE    = 16'd5000;
    localparam t_ivl RST_CLIENTS_CYCLE    = 16'd10000;
    localparam t_ivl RST_SHORT_OFF        = 16'd100;

endpackage

>>> hw/rtl/slbp_in_if.sv
interface slbp_in_if
    import slbp_pkg::*;
;
    logic    valid;
    logic    ready;
    t_status link_status;
    t_time   now_ms;

    modport source (output valid, output link_status, output now_ms, input ready);
    modport sink   (input valid, input link_status, input now_ms, output ready);
endinterface

>>> hw/rtl/slbp_out_if.sv
interface slbp_out_if;
    logic valid;
    logic ready;
    logic led_on;
    logic pin_level;

    modport source (output valid, output led_on, output pin_level, input ready);
    modport sink   (input valid, input led_on, input pin_level, output ready);
endinterface

>>> hw/rtl/status_led_blink_pattern.sv
// Path: an accepted input beat sits in the input register, then moves to the result
// register, where it is offered until taken.
// Throughput: one beat per cycle while o_result.ready keeps the result register
// draining; the status update is a single subtract-and-compare pass from the input
// register to the result register, so beats may follow back to back.
// Reset (i_rst_n, synchronous, active low) empties both registers, restores the
// configuration defaults, and sets the status to started with the LED off.
module status_led_blink_pattern
    import slbp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    slbp_in_if.sink         i_item,
    slbp_out_if.source      o_result,
    input  logic            i_cfg_we,
    input  t_cfg_idx        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    t_ivl r_started_blink;
    t_ivl r_connecting_blink;
    t_ivl r_ap_blink;
    t_ivl r_station_cycle;
    t_ivl r_clients_cycle;
    t_ivl r_short_off;
    logic r_active_low;

    // Pattern state, carried from one beat to the next.
    t_status r_last_status;
    t_time   r_last_toggle;
    t_time   r_cycle_start;
    logic    r_lamp;

    // Input register.
    logic    r_in_valid;
    t_status r_in_status;
    t_time   r_in_now;

    // Result register.
    logic r_out_valid;
    logic r_out_led;
    logic r_out_pin;

    // The result register may take a new beat when it is empty or being drained.
    logic w_advance;
    logic w_fire;

    assign w_advance    = !r_out_valid || o_result.ready;
    assign w_fire       = r_in_valid && w_advance;
    assign i_item.ready = !r_in_valid || w_advance;

    assign o_result.valid     = r_out_valid;
    assign o_result.led_on    = r_out_led;
    assign o_result.pin_level = r_out_pin;

    // Next-state logic for the beat that sits in the input register.
    logic    w_changed;
    t_time   w_toggle_base;
    t_time   w_cycle_base;
    logic    w_lamp_base;
    t_time   w_since_toggle;
    t_time   w_elapsed;
    t_time   w_cycle;
    t_time   w_short;
    t_time   w_off_from;
    t_ivl    w_interval;
    logic    n_lamp;
    t_time   n_last_toggle;
    t_time   n_cycle_start;

    always_comb begin
        // A change of status turns the LED off and restarts both reference times.
        w_changed     = (r_in_status != r_last_status);
        w_toggle_base = w_changed ? r_in_now : r_last_toggle;
        w_cycle_base  = w_changed ? r_in_now : r_cycle_start;
        w_lamp_base   = w_changed ? 1'b0 : r_lamp;

        // All differences wrap modulo 2^32, as does cycle minus short-off.
        w_since_toggle = r_in_now - w_toggle_base;
        w_elapsed      = r_in_now - w_cycle_base;
        w_short        = {{(TIME_W-IVL_W){1'b0}}, r_short_off};

        case (r_in_status)
            ST_STARTED:    w_interval = r_started_blink;
            ST_CONNECTING: w_interval = r_connecting_blink;
            default:       w_interval = r_ap_blink;
        endcase

        if (r_in_status == ST_STATION) begin
            w_cycle = {{(TIME_W-IVL_W){1'b0}}, r_station_cycle};
        end else begin
            w_cycle = {{(TIME_W-IVL_W){1'b0}}, r_clients_cycle};
        end
        w_off_from = w_cycle - w_short;

        n_lamp        = w_lamp_base;
        n_last_toggle = w_toggle_base;
        n_cycle_start = w_cycle_base;

        case (r_in_status)
            ST_STARTED, ST_CONNECTING, ST_AP: begin
                // Blinking statuses toggle once their interval has elapsed.
                if (w_since_toggle >= {{(TIME_W-IVL_W){1'b0}}, w_interval}) begin
                    n_lamp        = !w_lamp_base;
                    n_last_toggle = r_in_now;
                end
            end
            ST_STATION, ST_STA_CLIENT, ST_AP_CLIENT: begin
                // Connected statuses: off, on after the short span, off near the
                // end, and on again when the cycle restarts. Early in the cycle
                // none of these fire and the LED holds.
                if (w_elapsed >= w_cycle) begin
                    n_lamp        = 1'b1;
                    n_cycle_start = r_in_now;
                end else if (w_elapsed >= w_off_from) begin
                    n_lamp = 1'b0;
                end else if (w_elapsed >= w_short) begin
                    n_lamp = 1'b1;
                end
            end
            default: begin
                // Unknown codes force the LED off.
                n_lamp = 1'b0;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started_blink    <= RST_STARTED_BLINK;
            r_connecting_blink <= RST_CONNECTING_BLINK;
            r_ap_blink         <= RST_AP_BLINK;
            r_station_cycle    <= RST_STATION_CYCLE;
            r_clients_cycle    <= RST_CLIENTS_CYCLE;
            r_short_off        <= RST_SHORT_OFF;
            r_active_low       <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STARTED_BLINK:    r_started_blink    <= i_cfg_data[IVL_W-1:0];
                CFG_CONNECTING_BLINK: r_connecting_blink <= i_cfg_data[IVL_W-1:0];
                CFG_AP_BLINK:         r_ap_blink         <= i_cfg_data[IVL_W-1:0];
                CFG_STATION_CYCLE:    r_station_cycle    <= i_cfg_data[IVL_W-1:0];
                CFG_CLIENTS_CYCLE:    r_clients_cycle    <= i_cfg_data[IVL_W-1:0];
                CFG_SHORT_OFF:        r_short_off        <= i_cfg_data[IVL_W-1:0];
                CFG_ACTIVE_LOW:       r_active_low       <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Input register: loads whenever it is empty or its beat moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_status <= i_item.link_status;
            r_in_now    <= i_item.now_ms;
        end
    end

    // Pattern state and the result register move together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_status <= ST_STARTED;
            r_last_toggle <= '0;
            r_cycle_start <= '0;
            r_lamp        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_last_status <= r_in_status;
                r_last_toggle <= n_last_toggle;
                r_cycle_start <= n_cycle_start;
                r_lamp        <= n_lamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_led <= n_lamp;
            r_out_pin <= n_lamp ^ r_active_low;
        end
    end

`ifndef SYNTHESIS
    a_unknown_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_in_status == ST_UNKNOWN_LO || r_in_status == ST_UNKNOWN_HI))
        |=> (!r_out_led && !r_lamp))
        else $error("unknown status did not force the LED off");

    a_status_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_last_status == $past(r_in_status)))
        else $error("last status not taken from the processed beat");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |=> (r_out_valid && $stable(r_out_led)))
        else $error("stalled result beat was lost or changed");

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> (r_in_valid && r_out_valid))
        else $error("input stalled while a register had room");
`endif

endmodule
